>>> hw/rtl/sgau_pkg.sv
// Shared types, sizes and codes of the synchronous gradient averaging block.
// No dependencies; the top module and the divider refer to it by scoped names.
package sgau_pkg;

    localparam int MAX_ELEMENTS = 256;
    localparam int MAX_WORKERS  = 8;
    localparam int ITER_SLOTS   = 4;

    localparam int ELEM_W   = $clog2(MAX_ELEMENTS);
    localparam int WORKER_W = $clog2(MAX_WORKERS);
    localparam int SLOT_W   = $clog2(ITER_SLOTS);
    localparam int LEN_W    = 9;
    localparam int WCNT_W   = 4;
    localparam int ITER_W   = 31;
    localparam int VAL_W    = 32;
    localparam int SUM_W    = VAL_W + WORKER_W;
    localparam int CLR_W    = WORKER_W + ELEM_W;
    localparam int GRAD_AW  = SLOT_W + CLR_W;
    localparam int GRAD_DEPTH = ITER_SLOTS * MAX_WORKERS * MAX_ELEMENTS;

    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [WORKER_W-1:0] worker_t;
    typedef logic [ELEM_W-1:0]   elem_t;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_SUBMIT = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;
    localparam logic [1:0] REQ_QUERY  = 2'd3;

    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_NO_SLOT = 2'd1;
    localparam logic [1:0] ERR_RANGE   = 2'd2;

    localparam logic CFG_WORKER_COUNT  = 1'b0;
    localparam logic CFG_VECTOR_LENGTH = 1'b1;

endpackage

>>> hw/rtl/sync_gradient_average_update.sv
// Synchronous gradient averaging: load, submit, read and query beats in, one result beat out.
// Load, query and a submission to an open slot answer in the next cycle, one beat a cycle while the
// output is not stalled; a read passes ST_READ. Allocating a slot clears its gradients first.
// Completing an iteration walks the vector: per element 8 gradient RAM reads (ST_SUM), one more
// accumulate (ST_SUMLAST), then the serial divider, whose done writes the element.
// Input is stalled during each walk. Reset (aresetn low, synchronous) clears slot table,
// config to 1 and 256, output valid.
module sync_gradient_average_update (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: worker[2:0], iteration_number[33:3], element_index[41:34],
    //          element_value[73:42], zero fill [79:74]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    input  logic        s_tlast,   // final_element
    // m_tdata: param_value[31:0], update_done[32], iteration_aggregated[33],
    //          workers_seen[37:34], error_code[39:38]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam int NS = sgau_pkg::ITER_SLOTS;
    localparam int VW = sgau_pkg::VAL_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_CLEAR, ST_WRITE, ST_SUM, ST_SUMLAST, ST_DIV
    } state_t;

    state_t state_reg, state_next;
    logic [sgau_pkg::WCNT_W-1:0] wc_reg, wc_next;
    logic [sgau_pkg::LEN_W-1:0]  vlen_reg, vlen_next;
    logic                        present_reg, present_next;
    logic [sgau_pkg::ITER_W-1:0] tag_reg [NS];
    logic [sgau_pkg::ITER_W-1:0] tag_next [NS];
    logic [NS-1:0]               use_reg, use_next;
    logic [NS-1:0]               agg_reg, agg_next;
    logic [sgau_pkg::MAX_WORKERS-1:0] mask_reg [NS];
    logic [sgau_pkg::MAX_WORKERS-1:0] mask_next [NS];

    sgau_pkg::worker_t lw_reg, lw_next;
    sgau_pkg::elem_t   lidx_reg, lidx_next;
    logic [VW-1:0]     lval_reg, lval_next;
    logic              lfin_reg, lfin_next;
    sgau_pkg::slot_t   lslot_reg, lslot_next;
    logic [sgau_pkg::CLR_W-1:0] clr_reg, clr_next;
    sgau_pkg::elem_t   e_reg, e_next;
    sgau_pkg::worker_t wk_reg, wk_next;
    logic              rdp_reg, rdp_next;
    sgau_pkg::worker_t rdw_reg, rdw_next;
    logic signed [sgau_pkg::SUM_W-1:0] sum_reg, sum_next, sum_add;

    logic              m_valid_reg, m_valid_next;
    logic [VW-1:0]     o_pval_reg, o_pval_next;
    logic              o_done_reg, o_done_next;
    logic              o_agg_reg, o_agg_next;
    logic [sgau_pkg::WCNT_W-1:0] o_seen_reg, o_seen_next;
    logic [1:0]        o_err_reg, o_err_next;

    // beat fields
    logic [1:0]                  in_req;
    sgau_pkg::worker_t           in_w;
    logic [sgau_pkg::ITER_W-1:0] in_iter;
    sgau_pkg::elem_t             in_idx;
    logic [VW-1:0]               in_val;

    logic [sgau_pkg::LEN_W-1:0] eff_len;
    logic                       idx_ok;
    logic                       accept;
    logic                       hit_any, free_any, agg_any;
    sgau_pkg::slot_t            hit_slot, free_slot, agg_slot, sel_slot;
    logic [sgau_pkg::MAX_WORKERS-1:0] mask_sel, mask_upd;

    sgau_pkg::worker_t cur_w;
    sgau_pkg::elem_t   cur_idx;
    logic [VW-1:0]     cur_val;
    logic              cur_fin;

    logic                        grad_we, grad_re;
    logic [sgau_pkg::GRAD_AW-1:0] grad_waddr, grad_raddr;
    logic [VW-1:0]               grad_wdata, grad_rdata;
    logic                        par_we, par_re;
    sgau_pkg::elem_t             par_waddr, par_raddr;
    logic [VW-1:0]               par_wdata, par_rdata;

    logic                        div_start, div_done;
    logic signed [VW-1:0]        div_q;
    logic signed [VW:0]          upd_diff;
    logic [VW-1:0]               upd_val;

    assign in_w    = s_tdata[2:0];
    assign in_iter = s_tdata[33:3];
    assign in_idx  = s_tdata[41:34];
    assign in_val  = s_tdata[73:42];
    assign in_req  = s_tuser;

    assign eff_len  = (vlen_reg > sgau_pkg::LEN_W'(sgau_pkg::MAX_ELEMENTS))
                      ? sgau_pkg::LEN_W'(sgau_pkg::MAX_ELEMENTS) : vlen_reg;
    assign idx_ok   = {1'b0, in_idx} < eff_len;
    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // slot lookup, lowest slot wins
    always_comb begin
        hit_any   = 1'b0;
        free_any  = 1'b0;
        agg_any   = 1'b0;
        hit_slot  = '0;
        free_slot = '0;
        agg_slot  = '0;
        for (int i = NS - 1; i >= 0; i--) begin
            if (use_reg[i] && tag_reg[i] == in_iter) begin
                hit_any  = 1'b1;
                hit_slot = sgau_pkg::slot_t'(i);
            end
            if (!use_reg[i]) begin
                free_any  = 1'b1;
                free_slot = sgau_pkg::slot_t'(i);
            end
            if (agg_reg[i]) begin
                agg_any  = 1'b1;
                agg_slot = sgau_pkg::slot_t'(i);
            end
        end
    end

    assign sel_slot = (state_reg == ST_IDLE) ? hit_slot : lslot_reg;
    assign mask_sel = mask_reg[sel_slot];

    assign cur_w   = (state_reg == ST_IDLE) ? in_w    : lw_reg;
    assign cur_idx = (state_reg == ST_IDLE) ? in_idx  : lidx_reg;
    assign cur_val = (state_reg == ST_IDLE) ? in_val  : lval_reg;
    assign cur_fin = (state_reg == ST_IDLE) ? s_tlast : lfin_reg;
    assign mask_upd = mask_sel | (sgau_pkg::MAX_WORKERS'(1) << cur_w);

    assign sum_add = sum_reg + ((rdp_reg && mask_sel[rdw_reg])
                     ? sgau_pkg::SUM_W'(signed'(grad_rdata)) : '0);

    assign upd_diff = (VW + 1)'(signed'(par_rdata)) - (VW + 1)'(div_q);
    assign upd_val  = !present_reg ? div_q :
                      (upd_diff[VW] != upd_diff[VW-1])
                      ? (upd_diff[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}})
                      : upd_diff[VW-1:0];

    always_comb begin
        state_next   = state_reg;
        wc_next      = wc_reg;
        vlen_next    = vlen_reg;
        present_next = present_reg;
        tag_next     = tag_reg;
        use_next     = use_reg;
        agg_next     = agg_reg;
        mask_next    = mask_reg;
        lw_next      = lw_reg;
        lidx_next    = lidx_reg;
        lval_next    = lval_reg;
        lfin_next    = lfin_reg;
        lslot_next   = lslot_reg;
        clr_next     = clr_reg;
        e_next       = e_reg;
        wk_next      = wk_reg;
        rdp_next     = rdp_reg;
        rdw_next     = rdw_reg;
        sum_next     = sum_reg;
        m_valid_next = m_valid_reg;
        o_pval_next  = o_pval_reg;
        o_done_next  = o_done_reg;
        o_agg_next   = o_agg_reg;
        o_seen_next  = o_seen_reg;
        o_err_next   = o_err_reg;
        grad_we      = 1'b0;
        grad_waddr   = {sel_slot, cur_w, cur_idx};
        grad_wdata   = cur_val;
        grad_re      = 1'b0;
        grad_raddr   = {lslot_reg, wk_reg, e_reg};
        par_we       = 1'b0;
        par_waddr    = in_idx;
        par_wdata    = in_val;
        par_re       = 1'b0;
        par_raddr    = in_idx;
        div_start    = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            unique case (cfg_index[0])
                sgau_pkg::CFG_WORKER_COUNT:  wc_next   = cfg_data[sgau_pkg::WCNT_W-1:0];
                sgau_pkg::CFG_VECTOR_LENGTH: vlen_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_valid_next = 1'b1;
                    o_pval_next  = '0;
                    o_done_next  = 1'b0;
                    o_agg_next   = 1'b0;
                    o_seen_next  = '0;
                    o_err_next   = sgau_pkg::ERR_OK;
                    unique case (in_req)
                        sgau_pkg::REQ_LOAD: begin
                            if (idx_ok) begin
                                par_we       = 1'b1;
                                present_next = 1'b1;
                            end else begin
                                o_err_next = sgau_pkg::ERR_RANGE;
                            end
                        end
                        sgau_pkg::REQ_SUBMIT: begin
                            if (!idx_ok) begin
                                o_err_next = sgau_pkg::ERR_RANGE;
                            end else if (hit_any) begin
                                grad_we = 1'b1;
                                if (cur_fin) begin
                                    mask_next[sel_slot] = mask_upd;
                                    if (sgau_pkg::WCNT_W'($countones(mask_upd)) == wc_reg) begin
                                        m_valid_next = 1'b0;
                                        lslot_next   = sel_slot;
                                        e_next       = '0;
                                        wk_next      = '0;
                                        rdp_next     = 1'b0;
                                        sum_next     = '0;
                                        state_next   = ST_SUM;
                                    end
                                end
                            end else if (free_any || agg_any) begin
                                // claim a slot and clear its gradients before the write
                                m_valid_next = 1'b0;
                                lslot_next   = free_any ? free_slot : agg_slot;
                                tag_next[lslot_next]  = in_iter;
                                use_next[lslot_next]  = 1'b1;
                                agg_next[lslot_next]  = 1'b0;
                                mask_next[lslot_next] = '0;
                                lw_next    = in_w;
                                lidx_next  = in_idx;
                                lval_next  = in_val;
                                lfin_next  = s_tlast;
                                clr_next   = '0;
                                state_next = ST_CLEAR;
                            end else begin
                                o_err_next = sgau_pkg::ERR_NO_SLOT;
                            end
                        end
                        sgau_pkg::REQ_READ: begin
                            if (idx_ok) begin
                                m_valid_next = 1'b0;
                                par_re       = 1'b1;
                                state_next   = ST_READ;
                            end else begin
                                o_err_next = sgau_pkg::ERR_RANGE;
                            end
                        end
                        sgau_pkg::REQ_QUERY: begin
                            if (hit_any) begin
                                o_agg_next  = agg_reg[sel_slot];
                                o_seen_next = sgau_pkg::WCNT_W'($countones(mask_sel));
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                m_valid_next = 1'b1;
                o_pval_next  = par_rdata;
                state_next   = ST_IDLE;
            end
            ST_CLEAR: begin
                grad_we    = 1'b1;
                grad_waddr = {lslot_reg, clr_reg};
                grad_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == '1) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                grad_we      = 1'b1;
                m_valid_next = 1'b1;
                o_pval_next  = '0;
                o_done_next  = 1'b0;
                o_agg_next   = 1'b0;
                o_seen_next  = '0;
                o_err_next   = sgau_pkg::ERR_OK;
                state_next   = ST_IDLE;
                if (cur_fin) begin
                    mask_next[sel_slot] = mask_upd;
                    if (sgau_pkg::WCNT_W'($countones(mask_upd)) == wc_reg) begin
                        m_valid_next = 1'b0;
                        e_next       = '0;
                        wk_next      = '0;
                        rdp_next     = 1'b0;
                        sum_next     = '0;
                        state_next   = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                sum_next = sum_add;
                grad_re  = 1'b1;
                rdp_next = 1'b1;
                rdw_next = wk_reg;
                wk_next  = wk_reg + 1'b1;
                if (wk_reg == '1) begin
                    state_next = ST_SUMLAST;
                end
            end
            ST_SUMLAST: begin
                sum_next   = sum_add;
                rdp_next   = 1'b0;
                par_re     = 1'b1;
                par_raddr  = e_reg;
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    par_we    = 1'b1;
                    par_waddr = e_reg;
                    par_wdata = upd_val;
                    if ({1'b0, e_reg} == eff_len - 1'b1) begin
                        present_next        = 1'b1;
                        agg_next[lslot_reg] = 1'b1;
                        m_valid_next        = 1'b1;
                        o_pval_next         = '0;
                        o_done_next         = 1'b1;
                        o_agg_next          = 1'b0;
                        o_seen_next         = '0;
                        o_err_next          = sgau_pkg::ERR_OK;
                        state_next          = ST_IDLE;
                    end else begin
                        e_next     = e_reg + 1'b1;
                        wk_next    = '0;
                        sum_next   = '0;
                        state_next = ST_SUM;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wc_reg      <= sgau_pkg::WCNT_W'(1);
            vlen_reg    <= sgau_pkg::LEN_W'(sgau_pkg::MAX_ELEMENTS);
            present_reg <= 1'b0;
            use_reg     <= '0;
            agg_reg     <= '0;
            m_valid_reg <= 1'b0;
            rdp_reg     <= 1'b0;
            for (int i = 0; i < NS; i++) begin
                tag_reg[i]  <= '0;
                mask_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            wc_reg      <= wc_next;
            vlen_reg    <= vlen_next;
            present_reg <= present_next;
            use_reg     <= use_next;
            agg_reg     <= agg_next;
            m_valid_reg <= m_valid_next;
            rdp_reg     <= rdp_next;
            tag_reg     <= tag_next;
            mask_reg    <= mask_next;
        end
        lw_reg     <= lw_next;
        lidx_reg   <= lidx_next;
        lval_reg   <= lval_next;
        lfin_reg   <= lfin_next;
        lslot_reg  <= lslot_next;
        clr_reg    <= clr_next;
        e_reg      <= e_next;
        wk_reg     <= wk_next;
        rdw_reg    <= rdw_next;
        sum_reg    <= sum_next;
        o_pval_reg <= o_pval_next;
        o_done_reg <= o_done_next;
        o_agg_reg  <= o_agg_next;
        o_seen_reg <= o_seen_next;
        o_err_reg  <= o_err_next;
    end

    sgau_ram #(
        .WIDTH(VW),
        .DEPTH(sgau_pkg::GRAD_DEPTH)
    ) u_grad_ram (
        .aclk  (aclk),
        .we    (grad_we),
        .waddr (grad_waddr),
        .wdata (grad_wdata),
        .re    (grad_re),
        .raddr (grad_raddr),
        .rdata (grad_rdata)
    );

    sgau_ram #(
        .WIDTH(VW),
        .DEPTH(sgau_pkg::MAX_ELEMENTS)
    ) u_param_ram (
        .aclk  (aclk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (par_wdata),
        .re    (par_re),
        .raddr (par_raddr),
        .rdata (par_rdata)
    );

    sgau_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (wc_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {o_err_reg, o_seen_reg, o_agg_reg, o_done_reg, o_pval_reg};

`ifndef SYNTH
    a_agg_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        (agg_reg & ~use_reg) == '0)
        else $error("aggregated slot not in use");
    a_done_has_params: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && o_done_reg |-> present_reg)
        else $error("update reported without parameters");
    a_load_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && in_req == sgau_pkg::REQ_LOAD |=> m_valid_reg && state_reg == ST_IDLE)
        else $error("load beat did not answer next cycle");
    a_walk_mask_full: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SUM |-> sgau_pkg::WCNT_W'($countones(mask_reg[lslot_reg])) == wc_reg)
        else $error("averaging walk with incomplete worker set");
`endif

endmodule

>>> hw/rtl/sgau_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sgau_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/sgau_div.sv
// Bit-serial signed divider: gradient sum over a 4-bit worker count, truncating.
// Depends on sgau_pkg.
module sgau_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic signed [sgau_pkg::SUM_W-1:0] dividend,
    input  logic [sgau_pkg::WCNT_W-1:0]       divisor,
    output logic                             done,
    output logic signed [sgau_pkg::VAL_W-1:0] quotient
);

    localparam int CNT_W = $clog2(sgau_pkg::SUM_W);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [sgau_pkg::SUM_W-1:0]    work_reg, work_next;
    logic [sgau_pkg::WCNT_W-1:0]   rem_reg, rem_next;
    logic [sgau_pkg::WCNT_W-1:0]   d_reg, d_next;
    logic                          neg_reg, neg_next;
    logic [sgau_pkg::WCNT_W:0]     trial;
    logic [sgau_pkg::WCNT_W:0]     diff;
    logic [sgau_pkg::SUM_W-1:0]    signed_q;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        trial     = {rem_reg, work_reg[sgau_pkg::SUM_W-1]};
        diff      = trial - {1'b0, d_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            d_next    = divisor;
            neg_next  = dividend[sgau_pkg::SUM_W-1];
            work_next = dividend[sgau_pkg::SUM_W-1] ? -dividend : dividend;
        end else if (busy_reg) begin
            // one quotient bit a cycle, restoring form
            if (trial >= {1'b0, d_reg}) begin
                rem_next  = diff[sgau_pkg::WCNT_W-1:0];
                work_next = {work_reg[sgau_pkg::SUM_W-2:0], 1'b1};
            end else begin
                rem_next  = trial[sgau_pkg::WCNT_W-1:0];
                work_next = {work_reg[sgau_pkg::SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(sgau_pkg::SUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        work_reg <= work_next;
        rem_reg  <= rem_next;
        d_reg    <= d_next;
        neg_reg  <= neg_next;
    end

    assign signed_q = neg_reg ? -work_reg : work_reg;
    assign quotient = signed_q[sgau_pkg::VAL_W-1:0];
    assign done     = done_reg;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a run");
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !start |-> rem_reg < d_reg)
        else $error("divider remainder out of range");
`endif

endmodule
